// File: rtl/sm4_pkg.sv
// Shared types, constants and round-function helpers for the SM4 block cipher.
`timescale 1ns / 1ps

package sm4_pkg;

	localparam int SM4_ROUNDS = 32;
	localparam int WORD_W     = 32;
	localparam int CFG_W      = 64;
	localparam int CFG_IDX_W  = 3;

	typedef logic [WORD_W-1:0] word_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXPAND,
		ST_CRYPT,
		ST_FINISH
	} state_t;

	localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_IV_HIGH    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_IV_LOW     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CHAIN_MODE = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_DIRECTION  = 3'd5;

	// system parameter FK
	localparam word_t SM4_FK [4] = '{
		32'hA3B1BAC6, 32'h56AA3350, 32'h677D9197, 32'hB27022DC
	};

	localparam logic [7:0] SM4_SBOX [256] = '{
		8'hd6, 8'h90, 8'he9, 8'hfe, 8'hcc, 8'he1, 8'h3d, 8'hb7,
		8'h16, 8'hb6, 8'h14, 8'hc2, 8'h28, 8'hfb, 8'h2c, 8'h05,
		8'h2b, 8'h67, 8'h9a, 8'h76, 8'h2a, 8'hbe, 8'h04, 8'hc3,
		8'haa, 8'h44, 8'h13, 8'h26, 8'h49, 8'h86, 8'h06, 8'h99,
		8'h9c, 8'h42, 8'h50, 8'hf4, 8'h91, 8'hef, 8'h98, 8'h7a,
		8'h33, 8'h54, 8'h0b, 8'h43, 8'hed, 8'hcf, 8'hac, 8'h62,
		8'he4, 8'hb3, 8'h1c, 8'ha9, 8'hc9, 8'h08, 8'he8, 8'h95,
		8'h80, 8'hdf, 8'h94, 8'hfa, 8'h75, 8'h8f, 8'h3f, 8'ha6,
		8'h47, 8'h07, 8'ha7, 8'hfc, 8'hf3, 8'h73, 8'h17, 8'hba,
		8'h83, 8'h59, 8'h3c, 8'h19, 8'he6, 8'h85, 8'h4f, 8'ha8,
		8'h68, 8'h6b, 8'h81, 8'hb2, 8'h71, 8'h64, 8'hda, 8'h8b,
		8'hf8, 8'heb, 8'h0f, 8'h4b, 8'h70, 8'h56, 8'h9d, 8'h35,
		8'h1e, 8'h24, 8'h0e, 8'h5e, 8'h63, 8'h58, 8'hd1, 8'ha2,
		8'h25, 8'h22, 8'h7c, 8'h3b, 8'h01, 8'h21, 8'h78, 8'h87,
		8'hd4, 8'h00, 8'h46, 8'h57, 8'h9f, 8'hd3, 8'h27, 8'h52,
		8'h4c, 8'h36, 8'h02, 8'he7, 8'ha0, 8'hc4, 8'hc8, 8'h9e,
		8'hea, 8'hbf, 8'h8a, 8'hd2, 8'h40, 8'hc7, 8'h38, 8'hb5,
		8'ha3, 8'hf7, 8'hf2, 8'hce, 8'hf9, 8'h61, 8'h15, 8'ha1,
		8'he0, 8'hae, 8'h5d, 8'ha4, 8'h9b, 8'h34, 8'h1a, 8'h55,
		8'had, 8'h93, 8'h32, 8'h30, 8'hf5, 8'h8c, 8'hb1, 8'he3,
		8'h1d, 8'hf6, 8'he2, 8'h2e, 8'h82, 8'h66, 8'hca, 8'h60,
		8'hc0, 8'h29, 8'h23, 8'hab, 8'h0d, 8'h53, 8'h4e, 8'h6f,
		8'hd5, 8'hdb, 8'h37, 8'h45, 8'hde, 8'hfd, 8'h8e, 8'h2f,
		8'h03, 8'hff, 8'h6a, 8'h72, 8'h6d, 8'h6c, 8'h5b, 8'h51,
		8'h8d, 8'h1b, 8'haf, 8'h92, 8'hbb, 8'hdd, 8'hbc, 8'h7f,
		8'h11, 8'hd9, 8'h5c, 8'h41, 8'h1f, 8'h10, 8'h5a, 8'hd8,
		8'h0a, 8'hc1, 8'h31, 8'h88, 8'ha5, 8'hcd, 8'h7b, 8'hbd,
		8'h2d, 8'h74, 8'hd0, 8'h12, 8'hb8, 8'he5, 8'hb4, 8'hb0,
		8'h89, 8'h69, 8'h97, 8'h4a, 8'h0c, 8'h96, 8'h77, 8'h7e,
		8'h65, 8'hb9, 8'hf1, 8'h09, 8'hc5, 8'h6e, 8'hc6, 8'h84,
		8'h18, 8'hf0, 8'h7d, 8'hec, 8'h3a, 8'hdc, 8'h4d, 8'h20,
		8'h79, 8'hee, 8'h5f, 8'h3e, 8'hd7, 8'hcb, 8'h39, 8'h48
	};

	// byte-wise S-box substitution
	function automatic word_t sm4_tau(input word_t x);
		return {SM4_SBOX[x[31:24]], SM4_SBOX[x[23:16]], SM4_SBOX[x[15:8]], SM4_SBOX[x[7:0]]};
	endfunction

	function automatic word_t rotl(input word_t x, input int n);
		return (x << n) | (x >> (WORD_W - n));
	endfunction

	// CK word for key round idx: byte j (MSB first) is (4*idx + j) * 7 mod 256
	function automatic word_t sm4_ck(input logic [7:0] idx);
		word_t      v;
		logic [9:0] base;
		logic [9:0] prod;
		v = '0;
		for (int j = 0; j < 4; j++) begin
			base = {idx, 2'b00} + 10'(j);
			prod = base * 10'd7;
			v    = {v[23:0], prod[7:0]};
		end
		return v;
	endfunction

endpackage

// File: rtl/sm4_block_cipher_ecb_cbc.sv
// SM4 ECB/CBC encrypt/decrypt engine: top level with sequencer, round key memory and chaining.
`timescale 1ns / 1ps

// SM4 block cipher, 128-bit key and block, ECB or CBC, encrypt or decrypt. One round unit is
// reused for every round: a block goes from transfer in to result ready via a fetch of the
// first round key from the round key memory, ROUNDS = 32 rounds and a finish step that waits
// for a free output register; in_ready stays low meanwhile. After reset or key_high/key_low
// writes, the next block first expands the keys on the same round unit. The result sits in
// an output register, so the next block may be transferred in while it waits. The user
// writes configuration via cfg_we/cfg_index/cfg_wdata while the block is idle; the block does
// not enforce it. Indexes 0..5: key_high, key_low, iv_high, iv_low, chain_mode, direction.

module sm4_block_cipher_ecb_cbc #(
	parameter int ROUNDS = sm4_pkg::SM4_ROUNDS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [sm4_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sm4_pkg::CFG_W-1:0]      cfg_wdata,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [31:0]                    in_word0,
	input  logic [31:0]                    in_word1,
	input  logic [31:0]                    in_word2,
	input  logic [31:0]                    in_word3,
	input  logic                           first_block,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [31:0]                    out_word0,
	output logic [31:0]                    out_word1,
	output logic [31:0]                    out_word2,
	output logic [31:0]                    out_word3
);
	import sm4_pkg::*;

	localparam int CNT_W = $clog2(ROUNDS + 1);
	localparam int IDX_W = $clog2(ROUNDS);

	state_t state_q, state_d;

	logic [CFG_W-1:0] key_high_q, key_low_q, iv_high_q, iv_low_q;
	logic             chain_mode_q, direction_q;
	logic             keys_ready_q;
	word_t            chain_q [4];

	logic [CNT_W-1:0] cnt_q;
	word_t            x_q    [4];
	word_t            data_q [4];
	word_t            post_q [4];
	word_t            out_q  [4];
	logic             out_valid_q;
	word_t            rk_q;

	word_t            rk_mem [ROUNDS];

	word_t            blk      [4];
	word_t            link     [4];
	word_t            crypt_in [4];
	word_t            post     [4];
	word_t            key_init [4];
	word_t            res      [4];
	word_t            round_key;
	word_t            mix_in;
	word_t            next_word;
	logic             accept;
	logic             out_free;
	logic             expand_last;
	logic             crypt_last;
	logic [IDX_W-1:0] rd_idx;

	assign accept      = in_valid && in_ready;
	assign out_free    = !out_valid_q || out_ready;
	assign expand_last = (cnt_q == CNT_W'(ROUNDS - 1));
	assign crypt_last  = (cnt_q == CNT_W'(ROUNDS));
	assign in_ready    = (state_q == ST_IDLE);

	// input block prepared at transfer: CBC encrypt XORs before, CBC decrypt XORs after
	always_comb begin
		blk[0] = in_word0;
		blk[1] = in_word1;
		blk[2] = in_word2;
		blk[3] = in_word3;
		if (first_block) begin
			link[0] = iv_high_q[63:32];
			link[1] = iv_high_q[31:0];
			link[2] = iv_low_q[63:32];
			link[3] = iv_low_q[31:0];
		end else begin
			link = chain_q;
		end
		for (int i = 0; i < 4; i++) begin
			crypt_in[i] = (chain_mode_q && !direction_q) ? (blk[i] ^ link[i]) : blk[i];
			post[i]     = (chain_mode_q && direction_q) ? link[i] : '0;
		end
		key_init[0] = key_high_q[63:32] ^ SM4_FK[0];
		key_init[1] = key_high_q[31:0] ^ SM4_FK[1];
		key_init[2] = key_low_q[63:32] ^ SM4_FK[2];
		key_init[3] = key_low_q[31:0] ^ SM4_FK[3];
		// published reversed word order
		res[0] = x_q[3];
		res[1] = x_q[2];
		res[2] = x_q[1];
		res[3] = x_q[0];
	end

	assign rd_idx = direction_q ? (IDX_W'(ROUNDS - 1) - cnt_q[IDX_W-1:0]) : cnt_q[IDX_W-1:0];

	assign round_key = (state_q == ST_EXPAND) ? sm4_ck(8'(cnt_q[IDX_W-1:0])) : rk_q;
	assign mix_in    = x_q[1] ^ x_q[2] ^ x_q[3] ^ round_key;

	sm4_round u_round (
		.x0        (x_q[0]),
		.mix_in    (mix_in),
		.key_sched (state_q == ST_EXPAND),
		.next_word (next_word)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = keys_ready_q ? ST_CRYPT : ST_EXPAND;
				end
			end
			ST_EXPAND: begin
				if (expand_last) begin
					state_d = ST_CRYPT;
				end
			end
			ST_CRYPT: begin
				if (crypt_last) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// configuration, control and chaining state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q   <= '0;
			key_low_q    <= '0;
			iv_high_q    <= '0;
			iv_low_q     <= '0;
			chain_mode_q <= 1'b0;
			direction_q  <= 1'b0;
			keys_ready_q <= 1'b0;
			cnt_q        <= '0;
			out_valid_q  <= 1'b0;
			for (int i = 0; i < 4; i++) begin
				chain_q[i] <= '0;
			end
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_KEY_HIGH: begin
						key_high_q   <= cfg_wdata;
						keys_ready_q <= 1'b0;
					end
					REG_KEY_LOW: begin
						key_low_q    <= cfg_wdata;
						keys_ready_q <= 1'b0;
					end
					REG_IV_HIGH:    iv_high_q    <= cfg_wdata;
					REG_IV_LOW:     iv_low_q     <= cfg_wdata;
					REG_CHAIN_MODE: chain_mode_q <= cfg_wdata[0];
					REG_DIRECTION:  direction_q  <= cfg_wdata[0];
					default: ;
				endcase
			end else if (state_q == ST_EXPAND && expand_last) begin
				keys_ready_q <= 1'b1;
			end

			case (state_q)
				ST_EXPAND: cnt_q <= expand_last ? '0 : cnt_q + CNT_W'(1);
				ST_CRYPT:  cnt_q <= cnt_q + CNT_W'(1);
				default:   cnt_q <= '0;
			endcase

			if (state_q == ST_FINISH && out_free) begin
				out_valid_q <= 1'b1;
				if (chain_mode_q) begin
					chain_q <= direction_q ? data_q : res;
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// working words and result
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					data_q <= crypt_in;
					post_q <= post;
					x_q    <= keys_ready_q ? crypt_in : key_init;
				end
			end
			ST_EXPAND: begin
				if (expand_last) begin
					x_q <= data_q;
				end else begin
					x_q <= '{x_q[1], x_q[2], x_q[3], next_word};
				end
			end
			ST_CRYPT: begin
				// count zero only fetches the first round key
				if (cnt_q != '0) begin
					x_q <= '{x_q[1], x_q[2], x_q[3], next_word};
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					for (int i = 0; i < 4; i++) begin
						out_q[i] <= res[i] ^ post_q[i];
					end
				end
			end
			default: ;
		endcase
	end

	// round key memory: written during expansion, read into rk_q ahead of the round that uses it
	always_ff @(posedge clk) begin
		if (state_q == ST_EXPAND) begin
			rk_mem[cnt_q[IDX_W-1:0]] <= next_word;
		end
		if (state_q == ST_CRYPT) begin
			rk_q <= rk_mem[rd_idx];
		end
	end

	assign out_valid = out_valid_q;
	assign out_word0 = out_q[0];
	assign out_word1 = out_q[1];
	assign out_word2 = out_q[2];
	assign out_word3 = out_q[3];

	a_keys_before_crypt: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CRYPT) |-> keys_ready_q)
		else $error("round keys used before expansion");

	a_result_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_FINISH))
		else $error("result raised outside finish");

	a_transfer_goes_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_EXPAND || state_q == ST_CRYPT))
		else $error("transfer did not start work");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CRYPT) |-> (cnt_q <= CNT_W'(ROUNDS)))
		else $error("round count overran");

endmodule

// File: rtl/sm4_round.sv
// Shared SM4 round unit: S-box layer, linear transform (data or key schedule) and XOR.
`timescale 1ns / 1ps

module sm4_round (
	input  sm4_pkg::word_t x0,
	input  sm4_pkg::word_t mix_in,
	input  logic           key_sched,
	output sm4_pkg::word_t next_word
);
	import sm4_pkg::*;

	word_t b;
	word_t lin;

	always_comb begin
		b = sm4_tau(mix_in);
		if (key_sched) begin
			lin = b ^ rotl(b, 13) ^ rotl(b, 23);
		end else begin
			lin = b ^ rotl(b, 2) ^ rotl(b, 10) ^ rotl(b, 18) ^ rotl(b, 24);
		end
		next_word = x0 ^ lin;
	end

endmodule

// File: tb/sv/tb.sv
// Self-checking testbench for the SM4 ECB/CBC block cipher engine.
`timescale 1ns / 1ps

module tb;
	import sm4_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = 80;
	localparam int RANDOM_BLOCKS  = 900;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

	localparam logic [CFG_W-1:0] MODE_ECB = 64'd0;
	localparam logic [CFG_W-1:0] MODE_CBC = 64'd1;
	localparam logic [CFG_W-1:0] DIR_ENC  = 64'd0;
	localparam logic [CFG_W-1:0] DIR_DEC  = 64'd1;

	localparam logic [31:0] KEY_MASK [4] = '{
		32'hA3B1BAC6, 32'h56AA3350, 32'h677D9197, 32'hB27022DC
	};

	localparam logic [7:0] SBOX_TAB [256] = '{
		8'hd6, 8'h90, 8'he9, 8'hfe, 8'hcc, 8'he1, 8'h3d, 8'hb7,
		8'h16, 8'hb6, 8'h14, 8'hc2, 8'h28, 8'hfb, 8'h2c, 8'h05,
		8'h2b, 8'h67, 8'h9a, 8'h76, 8'h2a, 8'hbe, 8'h04, 8'hc3,
		8'haa, 8'h44, 8'h13, 8'h26, 8'h49, 8'h86, 8'h06, 8'h99,
		8'h9c, 8'h42, 8'h50, 8'hf4, 8'h91, 8'hef, 8'h98, 8'h7a,
		8'h33, 8'h54, 8'h0b, 8'h43, 8'hed, 8'hcf, 8'hac, 8'h62,
		8'he4, 8'hb3, 8'h1c, 8'ha9, 8'hc9, 8'h08, 8'he8, 8'h95,
		8'h80, 8'hdf, 8'h94, 8'hfa, 8'h75, 8'h8f, 8'h3f, 8'ha6,
		8'h47, 8'h07, 8'ha7, 8'hfc, 8'hf3, 8'h73, 8'h17, 8'hba,
		8'h83, 8'h59, 8'h3c, 8'h19, 8'he6, 8'h85, 8'h4f, 8'ha8,
		8'h68, 8'h6b, 8'h81, 8'hb2, 8'h71, 8'h64, 8'hda, 8'h8b,
		8'hf8, 8'heb, 8'h0f, 8'h4b, 8'h70, 8'h56, 8'h9d, 8'h35,
		8'h1e, 8'h24, 8'h0e, 8'h5e, 8'h63, 8'h58, 8'hd1, 8'ha2,
		8'h25, 8'h22, 8'h7c, 8'h3b, 8'h01, 8'h21, 8'h78, 8'h87,
		8'hd4, 8'h00, 8'h46, 8'h57, 8'h9f, 8'hd3, 8'h27, 8'h52,
		8'h4c, 8'h36, 8'h02, 8'he7, 8'ha0, 8'hc4, 8'hc8, 8'h9e,
		8'hea, 8'hbf, 8'h8a, 8'hd2, 8'h40, 8'hc7, 8'h38, 8'hb5,
		8'ha3, 8'hf7, 8'hf2, 8'hce, 8'hf9, 8'h61, 8'h15, 8'ha1,
		8'he0, 8'hae, 8'h5d, 8'ha4, 8'h9b, 8'h34, 8'h1a, 8'h55,
		8'had, 8'h93, 8'h32, 8'h30, 8'hf5, 8'h8c, 8'hb1, 8'he3,
		8'h1d, 8'hf6, 8'he2, 8'h2e, 8'h82, 8'h66, 8'hca, 8'h60,
		8'hc0, 8'h29, 8'h23, 8'hab, 8'h0d, 8'h53, 8'h4e, 8'h6f,
		8'hd5, 8'hdb, 8'h37, 8'h45, 8'hde, 8'hfd, 8'h8e, 8'h2f,
		8'h03, 8'hff, 8'h6a, 8'h72, 8'h6d, 8'h6c, 8'h5b, 8'h51,
		8'h8d, 8'h1b, 8'haf, 8'h92, 8'hbb, 8'hdd, 8'hbc, 8'h7f,
		8'h11, 8'hd9, 8'h5c, 8'h41, 8'h1f, 8'h10, 8'h5a, 8'hd8,
		8'h0a, 8'hc1, 8'h31, 8'h88, 8'ha5, 8'hcd, 8'h7b, 8'hbd,
		8'h2d, 8'h74, 8'hd0, 8'h12, 8'hb8, 8'he5, 8'hb4, 8'hb0,
		8'h89, 8'h69, 8'h97, 8'h4a, 8'h0c, 8'h96, 8'h77, 8'h7e,
		8'h65, 8'hb9, 8'hf1, 8'h09, 8'hc5, 8'h6e, 8'hc6, 8'h84,
		8'h18, 8'hf0, 8'h7d, 8'hec, 8'h3a, 8'hdc, 8'h4d, 8'h20,
		8'h79, 8'hee, 8'h5f, 8'h3e, 8'hd7, 8'hcb, 8'h39, 8'h48
	};

	logic                 clk         = 1'b0;
	logic                 arst_n      = 1'b0;
	logic                 cfg_we      = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index   = '0;
	logic [CFG_W-1:0]     cfg_wdata   = '0;
	logic                 in_valid    = 1'b0;
	logic                 in_ready;
	logic [31:0]          in_word0    = '0;
	logic [31:0]          in_word1    = '0;
	logic [31:0]          in_word2    = '0;
	logic [31:0]          in_word3    = '0;
	logic                 first_block = 1'b0;
	logic                 out_valid;
	logic                 out_ready   = 1'b0;
	logic [31:0]          out_word0;
	logic [31:0]          out_word1;
	logic [31:0]          out_word2;
	logic [31:0]          out_word3;

	// predictor copy of the register file and cipher state
	logic [63:0]  key_hi_q, key_lo_q, iv_hi_q, iv_lo_q;
	bit           cbc_on, decrypt_on;
	logic [31:0]  round_key [32];
	bit           schedule_valid;
	logic [127:0] chain_block;

	logic [127:0] pending_results [$];
	int           mismatch_count = 0;
	bit           tx_quiet = 1'b0;
	bit           rx_quiet = 1'b0;
	int           idle_cycles = 0;
	int           stall_left = 0;

	sm4_block_cipher_ecb_cbc u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_word0   (in_word0),
		.in_word1   (in_word1),
		.in_word2   (in_word2),
		.in_word3   (in_word3),
		.first_block(first_block),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_word0  (out_word0),
		.out_word1  (out_word1),
		.out_word2  (out_word2),
		.out_word3  (out_word3)
	);

	always #10 clk = ~clk;

	function automatic logic [31:0] sbox_word(input logic [31:0] x);
		return {SBOX_TAB[x[31:24]], SBOX_TAB[x[23:16]], SBOX_TAB[x[15:8]], SBOX_TAB[x[7:0]]};
	endfunction

	function automatic logic [31:0] rot_left(input logic [31:0] x, input int n);
		logic [63:0] d;
		d = {x, x} << n;
		return d[63:32];
	endfunction

	function automatic logic [31:0] linear_data(input logic [31:0] x);
		logic [31:0] b;
		b = sbox_word(x);
		return b ^ rot_left(b, 2) ^ rot_left(b, 10) ^ rot_left(b, 18) ^ rot_left(b, 24);
	endfunction

	function automatic logic [31:0] linear_key(input logic [31:0] x);
		logic [31:0] b;
		b = sbox_word(x);
		return b ^ rot_left(b, 13) ^ rot_left(b, 23);
	endfunction

	// CK byte j of word i: (4i + j) * 7 mod 256, MSB first
	function automatic logic [31:0] ck_word(input int i);
		logic [31:0] v;
		v = '0;
		for (int j = 0; j < 4; j++)
			v = {v[23:0], 8'(((4 * i + j) * 7) & 255)};
		return v;
	endfunction

	task automatic expand_key_schedule();
		logic [31:0] k [4];
		logic [31:0] n;
		k[0] = key_hi_q[63:32] ^ KEY_MASK[0];
		k[1] = key_hi_q[31:0] ^ KEY_MASK[1];
		k[2] = key_lo_q[63:32] ^ KEY_MASK[2];
		k[3] = key_lo_q[31:0] ^ KEY_MASK[3];
		for (int i = 0; i < 32; i++) begin
			n = k[0] ^ linear_key(k[1] ^ k[2] ^ k[3] ^ ck_word(i));
			round_key[i] = n;
			k[0] = k[1];
			k[1] = k[2];
			k[2] = k[3];
			k[3] = n;
		end
		schedule_valid = 1'b1;
	endtask

	// block packed word 0 in the top bits; output in reversed word order
	function automatic logic [127:0] sm4_rounds(input logic [127:0] blk, input bit dec);
		logic [31:0] x [4];
		logic [31:0] rk;
		logic [31:0] n;
		x[0] = blk[127:96];
		x[1] = blk[95:64];
		x[2] = blk[63:32];
		x[3] = blk[31:0];
		for (int i = 0; i < 32; i++) begin
			rk = dec ? round_key[31 - i] : round_key[i];
			n = x[0] ^ linear_data(x[1] ^ x[2] ^ x[3] ^ rk);
			x[0] = x[1];
			x[1] = x[2];
			x[2] = x[3];
			x[3] = n;
		end
		return {x[3], x[2], x[1], x[0]};
	endfunction

	task automatic predict_result(input logic [127:0] blk, input bit first,
			output logic [127:0] res);
		logic [127:0] link;
		if (!schedule_valid)
			expand_key_schedule();
		if (!cbc_on) begin
			res = sm4_rounds(blk, decrypt_on);
		end else begin
			link = first ? {iv_hi_q, iv_lo_q} : chain_block;
			// chain always holds the ciphertext-side block
			if (!decrypt_on) begin
				res = sm4_rounds(blk ^ link, 1'b0);
				chain_block = res;
			end else begin
				res = sm4_rounds(blk, 1'b1) ^ link;
				chain_block = blk;
			end
		end
	endtask

	task automatic apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		case (idx)
			REG_KEY_HIGH: begin
				key_hi_q = data;
				schedule_valid = 1'b0;
			end
			REG_KEY_LOW: begin
				key_lo_q = data;
				schedule_valid = 1'b0;
			end
			REG_IV_HIGH:    iv_hi_q = data;
			REG_IV_LOW:     iv_lo_q = data;
			REG_CHAIN_MODE: cbc_on = data[0];
			REG_DIRECTION:  decrypt_on = data[0];
			default: ;
		endcase
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		apply_reg(idx, data);
	endtask

	// mostly back-to-back, sometimes short, rarely long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 4);
		return $urandom_range(10, 60);
	endfunction

	function automatic logic [31:0] rand_word();
		int r;
		r = $urandom_range(0, 15);
		if (r == 0)
			return 32'h0;
		if (r == 1)
			return 32'hFFFF_FFFF;
		return $urandom;
	endfunction

	function automatic logic [63:0] rand_cfg();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return 64'h0;
		if (r == 1)
			return '1;
		return {$urandom, $urandom};
	endfunction

	task automatic send_block(input logic [31:0] w0, input logic [31:0] w1,
			input logic [31:0] w2, input logic [31:0] w3, input bit first);
		int gap;
		logic [127:0] res;
		gap = tx_quiet ? 0 : pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_word0 <= w0;
		in_word1 <= w1;
		in_word2 <= w2;
		in_word3 <= w3;
		first_block <= first;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		predict_result({w0, w1, w2, w3}, first, res);
		pending_results.push_back(res);
	endtask

	task automatic send_random(input bit first);
		send_block(rand_word(), rand_word(), rand_word(), rand_word(), first);
	endtask

	task automatic wait_results_done();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic report_mismatch(input string what, input logic [127:0] got,
			input logic [127:0] want);
		$display("%0t ns: %s got %0h want %0h", $time, what, got, want);
		mismatch_count++;
	endtask

	always @(posedge clk) begin : result_check
		logic [127:0] want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result", {out_word0, out_word1, out_word2, out_word3},
					'0);
			end else begin
				want = pending_results.pop_front();
				if (out_word0 !== want[127:96])
					report_mismatch("out_word0", 128'(out_word0), 128'(want[127:96]));
				if (out_word1 !== want[95:64])
					report_mismatch("out_word1", 128'(out_word1), 128'(want[95:64]));
				if (out_word2 !== want[63:32])
					report_mismatch("out_word2", 128'(out_word2), 128'(want[63:32]));
				if (out_word3 !== want[31:0])
					report_mismatch("out_word3", 128'(out_word3), 128'(want[31:0]));
			end
		end
	end

	always @(negedge clk) begin
		if (rx_quiet) begin
			out_ready <= 1'b1;
		end else if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left--;
		end else begin
			out_ready <= 1'b1;
			stall_left = pick_gap();
		end
	end

	// no transfer on either side for too long means a hang
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic test_reset_state();
		// zero key expanded on first use, then CBC continues from the cleared chain
		send_block(32'h0, 32'h0, 32'h0, 32'h0, 1'b0);
		wait_results_done();
		write_reg(REG_CHAIN_MODE, MODE_CBC);
		send_random(1'b0);
	endtask

	task automatic test_standard_vector();
		wait_results_done();
		write_reg(REG_KEY_HIGH, 64'h0123_4567_89AB_CDEF);
		write_reg(REG_KEY_LOW, 64'hFEDC_BA98_7654_3210);
		write_reg(REG_CHAIN_MODE, MODE_ECB);
		write_reg(REG_DIRECTION, DIR_ENC);
		send_block(32'h0123_4567, 32'h89AB_CDEF, 32'hFEDC_BA98, 32'h7654_3210, 1'b0);
		wait_results_done();
		write_reg(REG_DIRECTION, DIR_DEC);
		send_block(32'h681E_DF34, 32'hD206_965E, 32'h86B3_E94F, 32'h536E_4246, 1'b0);
	endtask

	task automatic test_field_extremes();
		wait_results_done();
		write_reg(REG_KEY_HIGH, '1);
		write_reg(REG_KEY_LOW, '1);
		write_reg(REG_IV_HIGH, '1);
		write_reg(REG_IV_LOW, 64'h0);
		for (int m = 0; m < 2; m++) begin
			for (int d = 0; d < 2; d++) begin
				wait_results_done();
				write_reg(REG_CHAIN_MODE, m ? MODE_CBC : MODE_ECB);
				write_reg(REG_DIRECTION, d ? DIR_DEC : DIR_ENC);
				send_block(32'h0, 32'h0, 32'h0, 32'h0, 1'b1);
				send_block('1, '1, '1, '1, 1'b0);
			end
		end
	endtask

	task automatic test_key_rewrite();
		wait_results_done();
		write_reg(REG_CHAIN_MODE, MODE_CBC);
		write_reg(REG_DIRECTION, DIR_ENC);
		write_reg(REG_KEY_HIGH, rand_cfg());
		send_random(1'b1);
		wait_results_done();
		write_reg(REG_KEY_LOW, rand_cfg());
		send_random(1'b0);
	endtask

	task automatic test_iv_update();
		wait_results_done();
		write_reg(REG_IV_HIGH, rand_cfg());
		write_reg(REG_IV_LOW, rand_cfg());
		send_random(1'b1);
		wait_results_done();
		// new IV must not disturb the running chain
		write_reg(REG_IV_HIGH, rand_cfg());
		write_reg(REG_IV_LOW, rand_cfg());
		send_random(1'b0);
		send_random(1'b1);
	endtask

	task automatic test_direction_switch();
		wait_results_done();
		write_reg(REG_DIRECTION, DIR_ENC);
		send_random(1'b1);
		send_random(1'b0);
		wait_results_done();
		write_reg(REG_DIRECTION, DIR_DEC);
		send_random(1'b0);
		send_random(1'b0);
	endtask

	task automatic test_ecb_leaves_chain();
		wait_results_done();
		write_reg(REG_DIRECTION, DIR_ENC);
		send_random(1'b1);
		wait_results_done();
		write_reg(REG_CHAIN_MODE, MODE_ECB);
		send_random(1'b1);
		wait_results_done();
		write_reg(REG_CHAIN_MODE, MODE_CBC);
		send_random(1'b0);
	endtask

	task automatic test_ignored_writes();
		wait_results_done();
		write_reg(REG_SPARE_6, rand_cfg());
		write_reg(REG_SPARE_7, '1);
		// only bit 0 of the mode and direction registers counts
		write_reg(REG_CHAIN_MODE, 64'hFFFF_FFFF_FFFF_FFFE);
		write_reg(REG_DIRECTION, '1);
		send_random(1'b1);
		send_random(1'b0);
	endtask

	task automatic test_random_traffic();
		int sent;
		int phase;
		int n;
		bit first;
		sent = 0;
		phase = 0;
		while (sent < RANDOM_BLOCKS) begin
			wait_results_done();
			tx_quiet = (phase % 6 == 5);
			rx_quiet = tx_quiet;
			if ($urandom_range(0, 3) == 0)
				write_reg(REG_KEY_HIGH, rand_cfg());
			if ($urandom_range(0, 3) == 0)
				write_reg(REG_KEY_LOW, rand_cfg());
			if ($urandom_range(0, 1) == 0)
				write_reg(REG_IV_HIGH, rand_cfg());
			if ($urandom_range(0, 1) == 0)
				write_reg(REG_IV_LOW, rand_cfg());
			if ($urandom_range(0, 1) == 0)
				write_reg(REG_CHAIN_MODE, rand_cfg());
			if ($urandom_range(0, 1) == 0)
				write_reg(REG_DIRECTION, rand_cfg());
			if ($urandom_range(0, 7) == 0)
				write_reg($urandom_range(0, 1) ? REG_SPARE_6 : REG_SPARE_7, rand_cfg());
			n = $urandom_range(8, 40);
			for (int j = 0; j < n; j++) begin
				// CBC: mostly a chain opened by one start block, with rare restarts
				if (cbc_on)
					first = (j == 0) ? ($urandom_range(0, 7) != 0) : ($urandom_range(0, 15) == 0);
				else
					first = 1'($urandom_range(0, 1));
				send_random(first);
				if ($urandom_range(0, 99) == 0)
					wait_results_done();
			end
			sent += n;
			phase++;
		end
		tx_quiet = 1'b0;
		rx_quiet = 1'b0;
	endtask

	initial begin
		key_hi_q = '0;
		key_lo_q = '0;
		iv_hi_q = '0;
		iv_lo_q = '0;
		cbc_on = 1'b0;
		decrypt_on = 1'b0;
		schedule_valid = 1'b0;
		chain_block = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_state();
		test_standard_vector();
		test_field_extremes();
		test_key_rewrite();
		test_iv_update();
		test_direction_switch();
		test_ecb_leaves_chain();
		test_ignored_writes();
		test_random_traffic();

		wait_results_done();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
